// ===== src/eigenvalues_2x2_real_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 2x2 real eigenvalue block
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef EIGENVALUES_2X2_REAL_MACROS_SVH
`define EIGENVALUES_2X2_REAL_MACROS_SVH

`ifndef SYNTHESIS

`define EIG2R_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("eigenvalues_2x2_real: assertion failed");

`define EIG2R_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("eigenvalues_2x2_real: assertion failed");

`else

`define EIG2R_ASSERT_IMP(lbl, ck, rn, ante, cons)

`define EIG2R_ASSERT_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

// ===== src/eig2r_pkg.sv =====
// ----------------------------------------------------------------------------
// eig2r_pkg
// Shared types and constants of the 2x2 real eigenvalue block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eig2r_pkg;

  localparam int ENTRY_WIDTH_DEF = 16;
  localparam int OUT_WIDTH       = 18;

  typedef enum logic {
    STATUS_REAL    = 1'b0,
    STATUS_COMPLEX = 1'b1
  } eig2r_status_t;

  typedef struct packed {
    logic valid;
    logic cplx;
  } eig2r_ctl_t;

endpackage

`default_nettype wire

// ===== src/eig2r_in_if.sv =====
// ----------------------------------------------------------------------------
// eig2r_in_if
// Request channel carrying one 2x2 matrix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface eig2r_in_if #(
  parameter int ENTRY_WIDTH = eig2r_pkg::ENTRY_WIDTH_DEF
);

  logic                          valid;
  logic                          ready;
  logic signed [ENTRY_WIDTH-1:0] entry_a;
  logic signed [ENTRY_WIDTH-1:0] entry_b;
  logic signed [ENTRY_WIDTH-1:0] entry_c;
  logic signed [ENTRY_WIDTH-1:0] entry_d;

  modport source (output valid, output entry_a, output entry_b, output entry_c,
                  output entry_d, input ready);
  modport sink   (input valid, input entry_a, input entry_b, input entry_c,
                  input entry_d, output ready);

endinterface

`default_nettype wire

// ===== src/eig2r_out_if.sv =====
// ----------------------------------------------------------------------------
// eig2r_out_if
// Result channel carrying the two eigenvalues and the root status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface eig2r_out_if;

  logic                                  valid;
  logic                                  ready;
  logic signed [eig2r_pkg::OUT_WIDTH-1:0] eigen_first;
  logic signed [eig2r_pkg::OUT_WIDTH-1:0] eigen_second;
  logic                                  root_status;

  modport source (output valid, output eigen_first, output eigen_second,
                  output root_status, input ready);
  modport sink   (input valid, input eigen_first, input eigen_second,
                  input root_status, output ready);

endinterface

`default_nettype wire

// ===== src/eigenvalues_2x2_real.sv =====
// ----------------------------------------------------------------------------
// eigenvalues_2x2_real
// Real eigenvalues of a 2x2 fixed-point matrix, one per clock unless stalled.
// ----------------------------------------------------------------------------
// Each request is a matrix [[entry_a, entry_b], [entry_c, entry_d]] and gives
// one result: the two real eigenvalues, larger first, saturated to 18 bits, or
// zeros with root_status set when the discriminant is negative. A request is
// accepted every cycle while results drain. Each request passes through three
// front-end stages, one root cell per bit of the square root and the output
// register. Back pressure stalls only the stages that hold data, so bubbles
// are squeezed out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "eigenvalues_2x2_real_macros.svh"

module eigenvalues_2x2_real #(
  parameter int ENTRY_WIDTH = eig2r_pkg::ENTRY_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  eig2r_in_if.sink    in_ch,
  eig2r_out_if.source out_ch
);

  localparam int DW = 2 * ENTRY_WIDTH + 2;
  localparam int RW = ENTRY_WIDTH + 1;

  eig2r_pkg::eig2r_ctl_t          ctl_w  [RW+1];
  logic [DW-1:0]                  rem_w  [RW+1];
  logic [RW-1:0]                  root_w [RW+1];
  logic signed [ENTRY_WIDTH:0]    tr_w   [RW+1];
  logic                           rdy_w  [RW+1];

  eig2r_front #(
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .entry_a  (in_ch.entry_a),
    .entry_b  (in_ch.entry_b),
    .entry_c  (in_ch.entry_c),
    .entry_d  (in_ch.entry_d),
    .dn_ready (rdy_w[0]),
    .o_ctl    (ctl_w[0]),
    .o_rem    (rem_w[0]),
    .o_tr     (tr_w[0])
  );

  assign root_w[0] = '0;

  for (genvar j = 0; j < RW; j++) begin : g_cell
    eig2r_cell #(
      .ENTRY_WIDTH (ENTRY_WIDTH),
      .BIT         (RW - 1 - j)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .i_ctl    (ctl_w[j]),
      .i_rem    (rem_w[j]),
      .i_root   (root_w[j]),
      .i_tr     (tr_w[j]),
      .up_ready (rdy_w[j]),
      .dn_ready (rdy_w[j+1]),
      .o_ctl    (ctl_w[j+1]),
      .o_rem    (rem_w[j+1]),
      .o_root   (root_w[j+1]),
      .o_tr     (tr_w[j+1])
    );
  end

  eig2r_back #(
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .i_ctl        (ctl_w[RW]),
    .i_root       (root_w[RW]),
    .i_tr         (tr_w[RW]),
    .up_ready     (rdy_w[RW]),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .eigen_first  (out_ch.eigen_first),
    .eigen_second (out_ch.eigen_second),
    .root_status  (out_ch.root_status)
  );

  // A complex result carries zero eigenvalues.
  `EIG2R_ASSERT_IMP(a_complex_zero, clk, rst_n,
    out_ch.valid && (out_ch.root_status == eig2r_pkg::STATUS_COMPLEX),
    (out_ch.eigen_first == '0) && (out_ch.eigen_second == '0))

  // Real eigenvalues come out in order, larger first.
  `EIG2R_ASSERT_IMP(a_real_order, clk, rst_n,
    out_ch.valid && (out_ch.root_status == eig2r_pkg::STATUS_REAL),
    out_ch.eigen_first >= out_ch.eigen_second)

  // A result only appears after the last root cell held a valid request.
  `EIG2R_ASSERT_IMP(a_out_source, clk, rst_n,
    $rose(out_ch.valid),
    $past(ctl_w[RW].valid))

  // A valid request in the last cell moves on whenever the output can take it.
  `EIG2R_ASSERT_NXT(a_last_moves, clk, rst_n,
    ctl_w[RW].valid && rdy_w[RW],
    out_ch.valid)

endmodule

`default_nettype wire

// ===== src/eig2r_front.sv =====
// ----------------------------------------------------------------------------
// eig2r_front
// Three-stage front end forming the trace and the discriminant.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eig2r_front #(
  parameter int ENTRY_WIDTH = eig2r_pkg::ENTRY_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [ENTRY_WIDTH-1:0]     entry_a,
  input  wire logic signed [ENTRY_WIDTH-1:0]     entry_b,
  input  wire logic signed [ENTRY_WIDTH-1:0]     entry_c,
  input  wire logic signed [ENTRY_WIDTH-1:0]     entry_d,
  input  wire logic                              dn_ready,
  output eig2r_pkg::eig2r_ctl_t                  o_ctl,
  output logic [2*ENTRY_WIDTH+1:0]               o_rem,
  output logic signed [ENTRY_WIDTH:0]            o_tr
);

  localparam int W   = ENTRY_WIDTH;
  localparam int SQW = 2 * W + 2;
  localparam int PW  = 2 * W;
  localparam int DCW = 2 * W + 3;
  localparam int DW  = 2 * W + 2;

  logic                  a_valid_r, b_valid_r, c_valid_r;
  logic                  a_en, b_en, c_en;
  logic signed [W:0]     tr_a_r, diff_r, tr_a_nxt, diff_nxt;
  logic signed [W-1:0]   b_r, c_r;
  logic signed [W:0]     tr_b_r;
  logic signed [SQW-1:0] sq_r, sq_nxt;
  logic signed [PW-1:0]  bc_r, bc_nxt;
  logic signed [W:0]     tr_c_r;
  logic [DW-1:0]         rem_c_r;
  logic                  cplx_c_r;
  logic signed [DCW-1:0] disc_nxt;

  assign c_en     = !c_valid_r || dn_ready;
  assign b_en     = !b_valid_r || c_en;
  assign a_en     = !a_valid_r || b_en;
  assign in_ready = a_en;

  assign tr_a_nxt = (W + 1)'(entry_a) + (W + 1)'(entry_d);
  assign diff_nxt = (W + 1)'(entry_a) - (W + 1)'(entry_d);
  assign sq_nxt   = SQW'(diff_r) * SQW'(diff_r);
  assign bc_nxt   = PW'(b_r) * PW'(c_r);
  assign disc_nxt = DCW'(sq_r) + (DCW'(bc_r) <<< 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid_r <= in_valid;
      end
      if (b_en) begin
        b_valid_r <= a_valid_r;
      end
      if (c_en) begin
        c_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      tr_a_r <= tr_a_nxt;
      diff_r <= diff_nxt;
      b_r    <= entry_b;
      c_r    <= entry_c;
    end
    if (b_en) begin
      tr_b_r <= tr_a_r;
      sq_r   <= sq_nxt;
      bc_r   <= bc_nxt;
    end
    if (c_en) begin
      tr_c_r   <= tr_b_r;
      rem_c_r  <= disc_nxt[DW-1:0];
      cplx_c_r <= disc_nxt[DCW-1];
    end
  end

  assign o_ctl.valid = c_valid_r;
  assign o_ctl.cplx  = cplx_c_r;
  assign o_rem       = rem_c_r;
  assign o_tr        = tr_c_r;

endmodule

`default_nettype wire

// ===== src/eig2r_cell.sv =====
// ----------------------------------------------------------------------------
// eig2r_cell
// One square root cell that settles a single bit of the root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eig2r_cell #(
  parameter int ENTRY_WIDTH = eig2r_pkg::ENTRY_WIDTH_DEF,
  parameter int BIT         = 0
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire eig2r_pkg::eig2r_ctl_t    i_ctl,
  input  wire logic [2*ENTRY_WIDTH+1:0] i_rem,
  input  wire logic [ENTRY_WIDTH:0]     i_root,
  input  wire logic signed [ENTRY_WIDTH:0] i_tr,
  output logic                          up_ready,
  input  wire logic                     dn_ready,
  output eig2r_pkg::eig2r_ctl_t         o_ctl,
  output logic [2*ENTRY_WIDTH+1:0]      o_rem,
  output logic [ENTRY_WIDTH:0]          o_root,
  output logic signed [ENTRY_WIDTH:0]   o_tr
);

  localparam int DW = 2 * ENTRY_WIDTH + 2;
  localparam int RW = ENTRY_WIDTH + 1;

  eig2r_pkg::eig2r_ctl_t ctl_r;
  logic [DW-1:0]         rem_r, rem_nxt;
  logic [RW-1:0]         root_r, root_nxt;
  logic signed [RW-1:0]  tr_r;
  logic [DW-1:0]         term;
  logic                  take;
  logic                  en;

  // The trial term is the growth of the square when this bit is set.
  assign term = (DW'(i_root) << (BIT + 1)) | (DW'(1) << (2 * BIT));
  assign take = (i_rem >= term);

  assign rem_nxt  = take ? (i_rem - term) : i_rem;
  assign root_nxt = take ? (i_root | (RW'(1) << BIT)) : i_root;

  assign en       = !ctl_r.valid || dn_ready;
  assign up_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= i_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      tr_r   <= i_tr;
    end
  end

  assign o_ctl  = ctl_r;
  assign o_rem  = rem_r;
  assign o_root = root_r;
  assign o_tr   = tr_r;

endmodule

`default_nettype wire

// ===== src/eig2r_back.sv =====
// ----------------------------------------------------------------------------
// eig2r_back
// Halving, saturation and the output register of the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eig2r_back #(
  parameter int ENTRY_WIDTH = eig2r_pkg::ENTRY_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire eig2r_pkg::eig2r_ctl_t             i_ctl,
  input  wire logic [ENTRY_WIDTH:0]              i_root,
  input  wire logic signed [ENTRY_WIDTH:0]       i_tr,
  output logic                                   up_ready,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [eig2r_pkg::OUT_WIDTH-1:0] eigen_first,
  output logic signed [eig2r_pkg::OUT_WIDTH-1:0] eigen_second,
  output logic                                   root_status
);

  localparam int OW = eig2r_pkg::OUT_WIDTH;
  localparam int SW = ENTRY_WIDTH + 3;
  localparam int HW = ENTRY_WIDTH + 2;
  localparam int MW = ((HW > OW) ? HW : OW) + 1;
  localparam logic signed [MW-1:0] SAT_HI = (MW'(1) <<< (OW - 1)) - MW'(1);
  localparam logic signed [MW-1:0] SAT_LO = ~SAT_HI;

  logic                           out_valid_r;
  logic signed [OW-1:0]           first_r, second_r;
  eig2r_pkg::eig2r_status_t       status_r;
  logic signed [SW-1:0]           root_ext, sum_hi, sum_lo;
  logic signed [HW-1:0]           half_hi, half_lo;
  logic                           en;

  function automatic logic signed [OW-1:0] saturate(input logic signed [HW-1:0] v);
    logic signed [MW-1:0] ext;
    ext = MW'(v);
    if (ext > SAT_HI) begin
      return SAT_HI[OW-1:0];
    end else if (ext < SAT_LO) begin
      return SAT_LO[OW-1:0];
    end
    return ext[OW-1:0];
  endfunction

  assign root_ext = $signed({2'b00, i_root});
  assign sum_hi   = SW'(i_tr) + root_ext;
  assign sum_lo   = SW'(i_tr) - root_ext;
  assign half_hi  = sum_hi[SW-1:1];
  assign half_lo  = sum_lo[SW-1:1];

  assign en       = !out_valid_r || out_ready;
  assign up_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= i_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (i_ctl.cplx) begin
        first_r  <= '0;
        second_r <= '0;
        status_r <= eig2r_pkg::STATUS_COMPLEX;
      end else begin
        first_r  <= saturate(half_hi);
        second_r <= saturate(half_lo);
        status_r <= eig2r_pkg::STATUS_REAL;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign eigen_first  = first_r;
  assign eigen_second = second_r;
  assign root_status  = status_r;

endmodule

`default_nettype wire

// ===== verif/tb_eigenvalues_2x2_real.sv =====
// ----------------------------------------------------------------------------
// tb_eigenvalues_2x2_real
// Self-checking regression for the 2x2 real eigenvalue block.
// ----------------------------------------------------------------------------
// Matrices are driven over the request channel. A scoreboard computes the
// expected eigenvalue pair of each accepted request and compares it, field by
// field and in order, with every accepted result. Directed corner matrices
// come first. Random phases follow with varying idle and stall rates, one
// long receiver hold-off that backs up the pipeline, and a full drain
// between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_eigenvalues_2x2_real;
  import eig2r_pkg::*;

  localparam int ENTRY_W          = ENTRY_WIDTH_DEF;
  localparam int PIPE_LATENCY     = ENTRY_W + 5;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int RANDOM_PER_PHASE = 345;
  localparam int NUM_PHASES       = 4;
  localparam int PRINT_CAP        = 100;

  typedef logic signed [ENTRY_W-1:0]   entry_t;
  typedef logic signed [OUT_WIDTH-1:0] eigen_t;

  typedef struct {
    entry_t a;
    entry_t b;
    entry_t c;
    entry_t d;
  } matrix_t;

  typedef struct {
    matrix_t       m;
    eigen_t        first;
    eigen_t        second;
    eig2r_status_t status;
  } eigen_pair_t;

  typedef enum {MAT_FULL, MAT_SMALL, MAT_SYMMETRIC, MAT_BOUNDARY} matrix_kind_t;

  class eigen_scoreboard;
    eigen_pair_t expected_eigen[$];
    int          errors;
    int          request_count;
    int          result_count;
    int          complex_count;
    int          repeated_root_count;

    function new();
      errors              = 0;
      request_count       = 0;
      result_count        = 0;
      complex_count       = 0;
      repeated_root_count = 0;
    endfunction

    function longint floor_root(longint v);
      longint r;
      longint cand;
      r = 0;
      for (int k = 20; k >= 0; k--) begin
        cand = r | (longint'(1) << k);
        if (cand * cand <= v) r = cand;
      end
      return r;
    endfunction

    function eigen_t clamp_out(longint v);
      if (v > 131071) v = 131071;
      if (v < -131072) v = -131072;
      return eigen_t'(v);
    endfunction

    function eigen_pair_t predict_eigen(matrix_t m);
      eigen_pair_t p;
      longint      trace;
      longint      diff;
      longint      disc;
      longint      root;
      p.m    = m;
      trace  = longint'(m.a) + longint'(m.d);
      diff   = longint'(m.a) - longint'(m.d);
      disc   = diff * diff + 4 * longint'(m.b) * longint'(m.c);
      if (disc < 0) begin
        p.first  = '0;
        p.second = '0;
        p.status = STATUS_COMPLEX;
        complex_count++;
      end else begin
        root     = floor_root(disc);
        p.first  = clamp_out((trace + root) >>> 1);
        p.second = clamp_out((trace - root) >>> 1);
        p.status = STATUS_REAL;
        if (disc == 0) repeated_root_count++;
      end
      return p;
    endfunction

    function int outstanding();
      return expected_eigen.size();
    endfunction

    function void note_request(matrix_t m);
      request_count++;
      expected_eigen.push_back(predict_eigen(m));
    endfunction

    task report_mismatch(string msg);
      if (errors < PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(eigen_t first, eigen_t second, logic status);
      eigen_pair_t want;
      string       tag;
      result_count++;
      if (expected_eigen.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                  result_count));
        return;
      end
      want = expected_eigen.pop_front();
      tag  = $sformatf("result %0d for [[%0d %0d] [%0d %0d]]", result_count,
                       want.m.a, want.m.b, want.m.c, want.m.d);
      if (first !== want.first)
        report_mismatch($sformatf("%s eigen_first got %0d want %0d",
                                  tag, first, want.first));
      if (second !== want.second)
        report_mismatch($sformatf("%s eigen_second got %0d want %0d",
                                  tag, second, want.second));
      if (status !== want.status)
        report_mismatch($sformatf("%s root_status got %b want %b",
                                  tag, status, want.status));
    endtask
  endclass

  logic clk;
  logic rst_n;

  eig2r_in_if #(.ENTRY_WIDTH(ENTRY_W)) in_ch ();
  eig2r_out_if                         out_ch ();

  eigenvalues_2x2_real #(
    .ENTRY_WIDTH(ENTRY_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  eigen_scoreboard sb;
  int              sender_idle_pct;
  int              recv_stall_pct;
  logic            hold_off_req;
  int              quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_request('{in_ch.entry_a, in_ch.entry_b, in_ch.entry_c, in_ch.entry_d});
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.eigen_first, out_ch.eigen_second, out_ch.root_status);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, sb.outstanding());
        $display("eigenvalues_2x2_real regression: fail");
        $finish;
      end
    end
  end

  task send_matrix(matrix_t m);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.entry_a <= m.a;
    in_ch.entry_b <= m.b;
    in_ch.entry_c <= m.c;
    in_ch.entry_d <= m.d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task wait_drain();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function matrix_t make_random_matrix();
    matrix_t      m;
    matrix_kind_t kind;
    int           pick;
    int           k;
    int           adj;
    entry_t       swap;
    pick = $urandom_range(99);
    if (pick < 35)      kind = MAT_FULL;
    else if (pick < 55) kind = MAT_SMALL;
    else if (pick < 70) kind = MAT_SYMMETRIC;
    else                kind = MAT_BOUNDARY;
    case (kind)
      MAT_FULL: begin
        m = '{entry_t'($urandom), entry_t'($urandom), entry_t'($urandom),
              entry_t'($urandom)};
      end
      MAT_SMALL: begin
        m.a = entry_t'(int'($urandom_range(511)) - 256);
        m.b = entry_t'(int'($urandom_range(511)) - 256);
        m.c = entry_t'(int'($urandom_range(511)) - 256);
        m.d = entry_t'(int'($urandom_range(511)) - 256);
      end
      MAT_SYMMETRIC: begin
        m.a = entry_t'($urandom);
        m.b = entry_t'($urandom);
        m.c = m.b;
        m.d = entry_t'($urandom);
      end
      default: begin
        // Build (a-d)^2 close to -4bc so the discriminant lands near zero.
        k   = $urandom_range(1, 181);
        adj = int'($urandom_range(2)) - 1;
        m.d = entry_t'(int'($urandom_range(60000)) - 30000);
        m.a = $urandom_range(1) ? entry_t'(m.d + 2 * k) : entry_t'(m.d - 2 * k);
        if ($urandom_range(1)) begin
          m.b = entry_t'(k);
          m.c = entry_t'(adj - k);
        end else begin
          m.b = entry_t'(k * k + adj);
          m.c = entry_t'(-1);
        end
        if ($urandom_range(1)) begin
          m.b = -m.b;
          m.c = -m.c;
        end
        if ($urandom_range(1)) begin
          swap = m.b;
          m.b  = m.c;
          m.c  = swap;
        end
      end
    endcase
    return m;
  endfunction

  matrix_t corner_list[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
    '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
    '{16'sd256, 16'sd0, 16'sd0, 16'sd256},
    '{16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768},
    '{-16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767},
    '{16'sd32767, 16'sd0, 16'sd0, -16'sd32768},
    '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767},
    '{16'sd0, 16'sd1, -16'sd1, 16'sd0},
    '{16'sd0, -16'sd32768, 16'sd32767, 16'sd0},
    '{16'sd0, 16'sd32767, -16'sd32768, 16'sd0},
    '{-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768},
    '{16'sd512, 16'sd256, -16'sd256, 16'sd0},
    '{16'sd2, 16'sd1, -16'sd1, 16'sd0},
    '{16'sd2, 16'sd2, -16'sd1, 16'sd0},
    '{-16'sd1, 16'sd2, 16'sd2, 16'sd0},
    '{-16'sd3, 16'sd0, 16'sd0, 16'sd0},
    '{-16'sd1, 16'sd0, 16'sd0, -16'sd2},
    '{16'sd0, 16'sd0, 16'sd0, -16'sd1},
    '{16'sd100, -16'sd32768, -16'sd32768, -16'sd100},
    '{16'sd5, 16'sd3, 16'sd7, -16'sd5}
  };

  int idle_by_phase[NUM_PHASES]  = '{0, 80, 0, 20};
  int stall_by_phase[NUM_PHASES] = '{0, 0, 80, 20};

  initial begin
    sb              = new();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_off_req    = 1'b0;
    quiet_cycles    = 0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.entry_a <= '0;
    in_ch.entry_b <= '0;
    in_ch.entry_c <= '0;
    in_ch.entry_d <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_list[i]) send_matrix(corner_list[i]);
    in_ch.valid <= 1'b0;
    wait_drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      sender_idle_pct = idle_by_phase[phase];
      recv_stall_pct  = stall_by_phase[phase];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (phase == 0 && n == 100) hold_off_req = 1'b1;
        send_matrix(make_random_matrix());
      end
      in_ch.valid <= 1'b0;
      wait_drain();
    end

    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived",
                                   sb.outstanding()));

    $display("Covered %0d matrices (%0d directed corners), %0d results checked.",
             sb.request_count, corner_list.size(), sb.result_count);
    $display("%0d had complex roots and %0d a repeated root; %0d mismatches seen.",
             sb.complex_count, sb.repeated_root_count, sb.errors);
    if (sb.errors == 0) begin
      $display("eigenvalues_2x2_real regression: pass");
    end else begin
      $display("eigenvalues_2x2_real regression: fail");
    end
    $finish;
  end

endmodule
